>>> src/plr_pkg.sv
// plr_pkg: shared constants and state types of the polyline resampler
// no dependencies
package plr_pkg;

  localparam int unsigned RadiusW  = 15;
  localparam int unsigned RadiusRst = 80;
  localparam int unsigned MulW     = 22;  // magnitudes below the far limit
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned D2W      = ProdW + 1;
  localparam int unsigned FarShift = 22;

  typedef enum logic [8:0] {
    FsIdle  = 9'b000000001,
    FsClass = 9'b000000010,
    FsSqX   = 9'b000000100,
    FsSqY   = 9'b000001000,
    FsSqR   = 9'b000010000,
    FsCmp   = 9'b000100000,
    FsSMul  = 9'b001000000,
    FsSCmp  = 9'b010000000,
    FsPush  = 9'b100000000
  } front_state_e;

  typedef enum logic [2:0] {
    BsIdle = 3'b001,
    BsDiv  = 3'b010,
    BsEmit = 3'b100
  } back_state_e;

endpackage

>>> src/plr_front.sv
// plr_front: takes vertices, measures them against the last emitted point
// and queues run commands; uses plr_pkg, one shared multiplier
module plr_front import plr_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 64,
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned NW = $clog2(MAX_STEPS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [RadiusW-1:0]           radius_i,
  input  logic                         push_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         line_start_i,
  output logic                         full_o,
  output logic                         cmd_push_o,
  input  logic                         cmd_full_i,
  output logic [COORD_BITS-1:0]        cmd_last_x_o,
  output logic [COORD_BITS-1:0]        cmd_last_y_o,
  output logic [DW-1:0]                cmd_dx_o,
  output logic [DW-1:0]                cmd_dy_o,
  output logic [NW-1:0]                cmd_n_o,
  output logic                         cmd_clamped_o
);

  front_state_e state_q, state_d;
  logic [COORD_BITS-1:0] px_q, py_q, last_x_q, last_y_q;
  logic                  start_q, active_q;
  logic [DW-1:0]         dx_q, dy_q;
  logic [MulW-1:0]       ax_q, ay_q, nr_q, mul_a, mul_b;
  logic [ProdW-1:0]      prod_q;
  logic [D2W-1:0]        d2_q;
  logic [NW-1:0]         k_q, n_q;
  logic                  clamp_q;

  logic [DW-1:0]         dx_c, dy_c, ax_c, ay_c;
  logic [DW+MulW-1:0]    ax_ext, ay_ext;
  logic                  far_big;
  logic [D2W-1:0]        r2_ext;
  logic [D2W+1:0]        d2x4, r2_ext4;

  assign dx_c = DW'($signed({px_q[COORD_BITS-1], px_q}) -
                    $signed({last_x_q[COORD_BITS-1], last_x_q}));
  assign dy_c = DW'($signed({py_q[COORD_BITS-1], py_q}) -
                    $signed({last_y_q[COORD_BITS-1], last_y_q}));
  assign ax_c = dx_c[DW-1] ? DW'(-dx_c) : dx_c;
  assign ay_c = dy_c[DW-1] ? DW'(-dy_c) : dy_c;
  assign ax_ext = {{MulW{1'b0}}, ax_c};
  assign ay_ext = {{MulW{1'b0}}, ay_c};
  assign far_big = ((ax_ext >> FarShift) != '0) || ((ay_ext >> FarShift) != '0);

  assign r2_ext  = {1'b0, prod_q};
  assign d2x4    = {d2_q, 2'b00};
  assign r2_ext4 = {2'b00, r2_ext};

  always_comb begin
    mul_a = nr_q;
    mul_b = nr_q;
    unique case (state_q)
      FsSqX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      FsSqY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      FsSqR: begin
        mul_a = MulW'(radius_i);
        mul_b = MulW'(radius_i);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsIdle:  if (push_i) state_d = FsClass;
      FsClass: begin
        if (start_q || !active_q || far_big) state_d = FsPush;
        else state_d = FsSqX;
      end
      FsSqX:   state_d = FsSqY;
      FsSqY:   state_d = FsSqR;
      FsSqR:   state_d = FsCmp;
      FsCmp: begin
        if (d2_q > r2_ext) state_d = FsSMul;
        else if (d2x4 < r2_ext4) state_d = FsIdle;  // near point dropped
        else state_d = FsPush;
      end
      FsSMul:  state_d = FsSCmp;
      FsSCmp: begin
        if ({1'b0, prod_q} >= d2_q || k_q == NW'(MAX_STEPS)) state_d = FsPush;
        else state_d = FsSMul;
      end
      FsPush:  if (!cmd_full_i) state_d = FsIdle;
      default: state_d = FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FsIdle;
      active_q <= 1'b0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_push_o) begin
        active_q <= 1'b1;
        last_x_q <= px_q;
        last_y_q <= py_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a * mul_b);
    unique case (state_q)
      FsIdle: begin
        if (push_i) begin
          px_q    <= point_x_i;
          py_q    <= point_y_i;
          start_q <= line_start_i;
        end
      end
      FsClass: begin
        start_q <= start_q || !active_q;
        dx_q    <= dx_c;
        dy_q    <= dy_c;
        ax_q    <= ax_ext[MulW-1:0];
        ay_q    <= ay_ext[MulW-1:0];
        n_q     <= (far_big && active_q && !start_q) ? NW'(MAX_STEPS) : NW'(1);
        clamp_q <= far_big && active_q && !start_q;
      end
      FsSqY: d2_q <= {1'b0, prod_q};
      FsSqR: d2_q <= d2_q + {1'b0, prod_q};
      FsCmp: begin
        nr_q    <= MulW'(radius_i);
        k_q     <= NW'(1);
        n_q     <= NW'(1);
        clamp_q <= 1'b0;
      end
      FsSCmp: begin
        if ({1'b0, prod_q} >= d2_q) begin
          n_q <= k_q;
        end else if (k_q == NW'(MAX_STEPS)) begin
          n_q     <= k_q;
          clamp_q <= 1'b1;
        end else begin
          k_q  <= k_q + NW'(1);
          nr_q <= nr_q + MulW'(radius_i);
        end
      end
      default: ;
    endcase
  end

  assign full_o        = (state_q != FsIdle);
  assign cmd_push_o    = (state_q == FsPush) && !cmd_full_i;
  assign cmd_last_x_o  = start_q ? px_q : last_x_q;
  assign cmd_last_y_o  = start_q ? py_q : last_y_q;
  assign cmd_dx_o      = start_q ? '0 : dx_q;
  assign cmd_dy_o      = start_q ? '0 : dy_q;
  assign cmd_n_o       = n_q;
  assign cmd_clamped_o = clamp_q;

endmodule

>>> src/plr_cmd_fifo.sv
// plr_cmd_fifo: two-entry queue of run commands between front and back
// depends on plr_pkg only by convention
module plr_cmd_fifo import plr_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= !wptr_q;
      if (rd_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

endmodule

>>> src/plr_back.sv
// plr_back: expands one run command into evenly spaced points
// uses plr_pkg; one restoring divider per axis, then add-and-correct steps
module plr_back import plr_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 64,
  parameter int unsigned COORD_BITS = 16,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned NW = $clog2(MAX_STEPS + 1),
  localparam int unsigned CW = $clog2(DW)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  input  logic [COORD_BITS-1:0] cmd_last_x_i,
  input  logic [COORD_BITS-1:0] cmd_last_y_i,
  input  logic [DW-1:0]         cmd_dx_i,
  input  logic [DW-1:0]         cmd_dy_i,
  input  logic [NW-1:0]         cmd_n_i,
  input  logic                  cmd_clamped_i,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic                  last_of_run_o,
  output logic                  steps_clamped_o,
  output logic                  empty_o,
  input  logic                  pop_i
);

  back_state_e state_q;
  logic [COORD_BITS-1:0] lx_q, ly_q, ox_q, oy_q;
  logic                  sx_q, sy_q, clamp_q, olast_q, oclamp_q, ovalid_q;
  logic [DW-1:0]         mx_q, my_q, qx_q, qy_q;
  logic [NW-1:0]         n_q, k_q, rx_q, ry_q, arx_q, ary_q;
  logic [CW-1:0]         cnt_q;

  logic [NW:0]           tx, ty, sumx, sumy;
  logic                  bx, by, cx, cy, emit;
  logic [DW-1:0]         nqx, nqy, ptx, pty;

  function automatic logic [DW-1:0] acc_add(logic [DW-1:0] a, logic [DW-1:0] b,
                                            logic c);
    acc_add = a + b + DW'(c);
  endfunction

  // one quotient bit per axis and cycle
  assign tx = {rx_q, mx_q[DW-1]};
  assign ty = {ry_q, my_q[DW-1]};
  assign bx = tx >= {1'b0, n_q};
  assign by = ty >= {1'b0, n_q};

  // running round(k*|d|/n) as quotient plus remainder biased by n/2
  assign sumx = {1'b0, arx_q} + {1'b0, rx_q};
  assign sumy = {1'b0, ary_q} + {1'b0, ry_q};
  assign cx   = sumx >= {1'b0, n_q};
  assign cy   = sumy >= {1'b0, n_q};
  assign nqx  = acc_add(qx_q, mx_q, cx);
  assign nqy  = acc_add(qy_q, my_q, cy);
  assign ptx  = sx_q ? DW'({lx_q[COORD_BITS-1], lx_q} - nqx)
                     : DW'({lx_q[COORD_BITS-1], lx_q} + nqx);
  assign pty  = sy_q ? DW'({ly_q[COORD_BITS-1], ly_q} - nqy)
                     : DW'({ly_q[COORD_BITS-1], ly_q} + nqy);

  assign emit      = (state_q == BsEmit) && (!ovalid_q || pop_i);
  assign cmd_pop_o = (state_q == BsIdle) && !cmd_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BsIdle;
      ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        BsIdle: if (!cmd_empty_i) state_q <= BsDiv;
        BsDiv:  if (cnt_q == CW'(DW - 1)) state_q <= BsEmit;
        BsEmit: if (emit && k_q == n_q) state_q <= BsIdle;
        default: state_q <= BsIdle;
      endcase
      if (emit) ovalid_q <= 1'b1;
      else if (pop_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BsIdle: begin
        lx_q    <= cmd_last_x_i;
        ly_q    <= cmd_last_y_i;
        sx_q    <= cmd_dx_i[DW-1];
        sy_q    <= cmd_dy_i[DW-1];
        mx_q    <= cmd_dx_i[DW-1] ? DW'(-cmd_dx_i) : cmd_dx_i;
        my_q    <= cmd_dy_i[DW-1] ? DW'(-cmd_dy_i) : cmd_dy_i;
        n_q     <= cmd_n_i;
        clamp_q <= cmd_clamped_i;
        rx_q    <= '0;
        ry_q    <= '0;
        cnt_q   <= '0;
      end
      BsDiv: begin
        mx_q  <= {mx_q[DW-2:0], bx};
        my_q  <= {my_q[DW-2:0], by};
        rx_q  <= bx ? NW'(tx - {1'b0, n_q}) : tx[NW-1:0];
        ry_q  <= by ? NW'(ty - {1'b0, n_q}) : ty[NW-1:0];
        cnt_q <= cnt_q + CW'(1);
        qx_q  <= '0;
        qy_q  <= '0;
        arx_q <= n_q >> 1;
        ary_q <= n_q >> 1;
        k_q   <= NW'(1);
      end
      BsEmit: begin
        if (emit) begin
          qx_q     <= nqx;
          qy_q     <= nqy;
          arx_q    <= cx ? NW'(sumx - {1'b0, n_q}) : sumx[NW-1:0];
          ary_q    <= cy ? NW'(sumy - {1'b0, n_q}) : sumy[NW-1:0];
          k_q      <= k_q + NW'(1);
          ox_q     <= ptx[COORD_BITS-1:0];
          oy_q     <= pty[COORD_BITS-1:0];
          olast_q  <= (k_q == n_q);
          oclamp_q <= clamp_q;
        end
      end
      default: ;
    endcase
  end

  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign last_of_run_o   = olast_q;
  assign steps_clamped_o = oclamp_q;
  assign empty_o         = !ovalid_q;

endmodule

>>> src/polyline_resampler_core.sv
// polyline_resampler_core: top level of the polyline resampler
// uses plr_pkg, plr_front, plr_cmd_fifo, plr_back
//
// Usage: vertices enter through a queue-style port (push/full); an item is
// taken at a clock edge with push high and full low. Results leave through
// a queue-style port (empty/pop); the oldest point sits on the out ports
// while empty is low and leaves on an edge with pop high.
// The spacing register is written through cfg_valid_i/cfg_data_i; ready is
// always high. Write it only while the block is idle.
// Front: a start or passthrough vertex goes from classify straight to push,
// a near or mid one through the squares and compare, a subdivided one on
// via the shared multiplier stepping n*r (n <= MAX_STEPS). Back: takes a
// command, divides, then one point per cycle unless a result is held. A
// two-entry command queue lets the front work ahead while the back waits
// on a stalled receiver; a held result keeps its value until popped.
// Reset clears the last emitted point to zero, marks no line active, sets
// the spacing to 80 and empties all queues.
module polyline_resampler_core import plr_pkg::*; #(
  parameter int unsigned MAX_STEPS  = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [RadiusW-1:0]           cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         line_start_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         last_of_run_o,
  output logic                         steps_clamped_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned NW = $clog2(MAX_STEPS + 1);
  localparam int unsigned CmdW = 2 * COORD_BITS + 2 * DW + NW + 1;

  logic [RadiusW-1:0]    radius_q;
  logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [COORD_BITS-1:0] f_lx, f_ly, b_lx, b_ly;
  logic [DW-1:0]         f_dx, f_dy, b_dx, b_dy;
  logic [NW-1:0]         f_n, b_n;
  logic                  f_cl, b_cl;
  logic [CmdW-1:0]       cmd_wdata, cmd_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(RadiusRst);
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  plr_front #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .radius_i      (radius_q),
    .push_i        (push),
    .point_x_i, .point_y_i, .line_start_i,
    .full_o        (full),
    .cmd_push_o    (cmd_push),
    .cmd_full_i    (cmd_full),
    .cmd_last_x_o  (f_lx),
    .cmd_last_y_o  (f_ly),
    .cmd_dx_o      (f_dx),
    .cmd_dy_o      (f_dy),
    .cmd_n_o       (f_n),
    .cmd_clamped_o (f_cl)
  );

  assign cmd_wdata = {f_lx, f_ly, f_dx, f_dy, f_n, f_cl};
  assign {b_lx, b_ly, b_dx, b_dy, b_n, b_cl} = cmd_rdata;

  plr_cmd_fifo #(.W(CmdW)) u_fifo (
    .clk_i, .rst_ni,
    .wr_i    (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  plr_back #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .cmd_last_x_i    (b_lx),
    .cmd_last_y_i    (b_ly),
    .cmd_dx_i        (b_dx),
    .cmd_dy_i        (b_dy),
    .cmd_n_i         (b_n),
    .cmd_clamped_i   (b_cl),
    .out_x_o, .out_y_o, .last_of_run_o, .steps_clamped_o,
    .empty_o         (empty),
    .pop_i           (pop)
  );

endmodule

>>> src/plr_checker.sv
// plr_checker: port-level checks of polyline_resampler_core
// bound to the top level below; uses plr_pkg
module plr_checker import plr_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_ready_o,
  input logic                  empty,
  input logic                  pop,
  input logic [COORD_BITS-1:0] out_x_o,
  input logic [COORD_BITS-1:0] out_y_o,
  input logic                  last_of_run_o,
  input logic                  steps_clamped_o
);

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_x_o) && $stable(out_y_o)))
    else $error("waiting result changed");

  // points of one run share the clamp flag
  a_run_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_run_o) |=>
    (empty || steps_clamped_o == $past(steps_clamped_o)))
    else $error("clamp flag changed inside a run");

  // no result shows during reset
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown in reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind polyline_resampler_core plr_checker #(.COORD_BITS(COORD_BITS)) u_plr_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .empty, .pop, .out_x_o, .out_y_o,
  .last_of_run_o, .steps_clamped_o
);
